[src/bmap_pkg.sv]
package bmap_pkg;

   // Request type codes
   localparam int REQ_TYPE_W = 3;
   localparam logic [REQ_TYPE_W-1:0] OP_GET         = 3'd0;
   localparam logic [REQ_TYPE_W-1:0] OP_SET         = 3'd1;
   localparam logic [REQ_TYPE_W-1:0] OP_CLEAR       = 3'd2;
   localparam logic [REQ_TYPE_W-1:0] OP_CLEAR_ALL   = 3'd3;
   localparam logic [REQ_TYPE_W-1:0] OP_FIRST_SET   = 3'd4;
   localparam logic [REQ_TYPE_W-1:0] OP_LAST_SET    = 3'd5;
   localparam logic [REQ_TYPE_W-1:0] OP_FIRST_CLEAR = 3'd6;
   localparam logic [REQ_TYPE_W-1:0] OP_LAST_CLEAR  = 3'd7;

   // Configuration register map
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 11;
   localparam logic [CSR_IDX_W-1:0] CSR_START_LENGTH = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GROW_ENABLE  = 1'd1;

   localparam int START_LENGTH_RESET = 1024;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic latch_req;
      logic clr_start;
      logic clr_write;
      logic rd_bit;
      logic commit;
      logic scan_start;
      logic scan_step;
      logic res_load;
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic                  clr_last;
      logic                  scan_done;
      logic                  rsp_free;
      logic [REQ_TYPE_W-1:0] op;
   } status_type;

endpackage

[src/bmap_ifs.sv]
interface bmap_req_if import bmap_pkg::*; #(parameter int IDX_W = 10) ();
   logic                  valid;
   logic                  ready;
   logic [REQ_TYPE_W-1:0] req_type;
   logic [IDX_W-1:0]      bit_index;

   modport source (output valid, req_type, bit_index, input ready);
   modport sink (input valid, req_type, bit_index, output ready);
endinterface

interface bmap_rsp_if #(parameter int IDX_W = 10, parameter int LEN_W = 11) ();
   logic             valid;
   logic             ready;
   logic             bit_value;
   logic             found;
   logic [IDX_W-1:0] found_index;
   logic [LEN_W-1:0] length_now;
   logic             error_code;

   modport source (output valid, bit_value, found, found_index, length_now, error_code,
                   input ready);
   modport sink (input valid, bit_value, found, found_index, length_now, error_code,
                 output ready);
endinterface

[src/bitmap_set_clear_find_first.sv]
// Get, set and clear go through the multiply, quotient, word read and write-back states;
// the result is loaded once the response register is free. Clear all sweeps every
// stored word, one per cycle, then loads its result. Searches read the words in use
// one per cycle. One request at a time: the next is accepted only once the result
// has been loaded and the controller is back in idle.
// Reset is synchronous, active high; after it and every start_length write a clearing pass over every word holds off requests.
module bitmap_set_clear_find_first import bmap_pkg::*; #(
   parameter int CAPACITY_BITS = 1024,
   parameter int WORD_BITS     = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   bmap_req_if.sink              req_bus,
   bmap_rsp_if.source            rsp_bus,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // Index and length widths follow from the capacity of the vector.
   localparam int IDX_W = $clog2(CAPACITY_BITS);
   localparam int LEN_W = $clog2(CAPACITY_BITS + 1);

   cmd_type    cmd;
   status_type status;

   // The controller sequences each request: bit operations go through an
   // address computation, a word read and a read-modify-write; searches and
   // clear all walk the word memory with a counter in the datapath.
   bmap_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath holds the word memory, the current length, the search
   // state and the result register that decouples the response side.
   bmap_dp #(
      .CAPACITY_BITS (CAPACITY_BITS),
      .WORD_BITS     (WORD_BITS),
      .IDX_W         (IDX_W),
      .LEN_W         (LEN_W)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_type        (req_bus.req_type),
      .bit_index       (req_bus.bit_index),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .rsp_ready       (rsp_bus.ready),
      .rsp_valid       (rsp_bus.valid),
      .rsp_bit_value   (rsp_bus.bit_value),
      .rsp_found       (rsp_bus.found),
      .rsp_found_index (rsp_bus.found_index),
      .rsp_length_now  (rsp_bus.length_now),
      .rsp_error_code  (rsp_bus.error_code)
   );

endmodule

[src/bmap_ctrl.sv]
module bmap_ctrl import bmap_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  status_type           status,
   output cmd_type              cmd
);

   localparam logic [2:0] S_CLR  = 3'd0;
   localparam logic [2:0] S_IDLE = 3'd1;
   localparam logic [2:0] S_MUL  = 3'd2;
   localparam logic [2:0] S_QUO  = 3'd3;
   localparam logic [2:0] S_RD   = 3'd4;
   localparam logic [2:0] S_WB   = 3'd5;
   localparam logic [2:0] S_SCAN = 3'd6;
   localparam logic [2:0] S_DONE = 3'd7;

   logic [2:0] state_ff, state_in;
   logic       clr_rsp_ff, clr_rsp_in;
   logic       cfg_restart;
   logic       accept;

   // A new start length wipes the store, so it restarts the clearing sweep.
   assign cfg_restart = csr_we && (csr_index == CSR_START_LENGTH);
   assign req_ready   = (state_ff == S_IDLE) && !cfg_restart;
   assign accept      = req_valid && req_ready;

   always_comb begin
      state_in   = state_ff;
      clr_rsp_in = clr_rsp_ff;
      cmd        = '0;
      unique case (state_ff)
         S_CLR: begin
            cmd.clr_write = 1'b1;
            if (status.clr_last) begin
               state_in = clr_rsp_ff ? S_DONE : S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               cmd.latch_req = 1'b1;
               priority if (status.op == OP_CLEAR_ALL) begin
                  cmd.clr_start = 1'b1;
                  clr_rsp_in    = 1'b1;
                  state_in      = S_CLR;
               end else if (status.op == OP_GET || status.op == OP_SET ||
                            status.op == OP_CLEAR) begin
                  state_in = S_MUL;
               end else begin
                  cmd.scan_start = 1'b1;
                  state_in       = S_SCAN;
               end
            end
         end
         S_MUL: begin
            state_in = S_QUO;
         end
         S_QUO: begin
            state_in = S_RD;
         end
         S_RD: begin
            cmd.rd_bit = 1'b1;
            state_in   = S_WB;
         end
         S_WB: begin
            if (status.rsp_free) begin
               cmd.commit   = 1'b1;
               cmd.res_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.scan_done) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (status.rsp_free) begin
               cmd.res_load = 1'b1;
               clr_rsp_in   = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLR;
         end
      endcase
      if (cfg_restart) begin
         cmd.clr_start = 1'b1;
         cmd.clr_write = 1'b0;
         clr_rsp_in    = 1'b0;
         state_in      = S_CLR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLR;
         clr_rsp_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         clr_rsp_ff <= clr_rsp_in;
      end
   end

endmodule

[src/bmap_dp.sv]
module bmap_dp import bmap_pkg::*; #(
   parameter int CAPACITY_BITS = 1024,
   parameter int WORD_BITS     = 32,
   parameter int IDX_W         = 10,
   parameter int LEN_W         = 11
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output status_type            status,
   input  logic [REQ_TYPE_W-1:0] req_type,
   input  logic [IDX_W-1:0]      bit_index,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output logic                  rsp_bit_value,
   output logic                  rsp_found,
   output logic [IDX_W-1:0]      rsp_found_index,
   output logic [LEN_W-1:0]      rsp_length_now,
   output logic                  rsp_error_code
);

   localparam int WORD_COUNT = (CAPACITY_BITS + WORD_BITS - 1) / WORD_BITS;
   localparam int AW         = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
   localparam int OFF_W      = $clog2(WORD_BITS);
   localparam int SH         = IDX_W + OFF_W;
   localparam int RECIP      = ((2 ** SH) + WORD_BITS - 1) / WORD_BITS;
   localparam int RCP_W      = SH + 1;
   localparam int PROD_W     = IDX_W + RCP_W;
   localparam int MUL_W      = IDX_W + 7;
   localparam int BASE_W     = LEN_W + 1;
   localparam int LEN_RST    = (START_LENGTH_RESET > CAPACITY_BITS) ?
                               CAPACITY_BITS : START_LENGTH_RESET;

   logic [WORD_BITS-1:0] word_mem [WORD_COUNT];

   logic [REQ_TYPE_W-1:0] op_ff;
   logic [IDX_W-1:0]      idx_ff;
   logic [PROD_W-1:0]     prod_ff;
   logic [IDX_W-1:0]      word_ff;
   logic [OFF_W-1:0]      off_ff;
   logic [WORD_BITS-1:0]  rd_data_ff;
   logic [LEN_W-1:0]      len_ff, len_in;
   logic                  grow_ff;
   logic [AW-1:0]         cnt_ff;
   logic [BASE_W-1:0]     base_iss_ff;
   logic [BASE_W-1:0]     ev_base_ff;
   logic                  ev_valid_ff;
   logic                  found_ff;
   logic [IDX_W-1:0]      fidx_ff;
   logic                  rsp_valid_ff;
   logic                  rsp_bit_ff, rsp_found_ff, rsp_err_ff;
   logic [IDX_W-1:0]      rsp_fidx_ff;
   logic [LEN_W-1:0]      rsp_len_ff;

   // Word address and bit offset of the requested index, by reciprocal multiply.
   logic [MUL_W-1:0] word_scaled, off_full;
   assign word_scaled = MUL_W'(word_ff) * MUL_W'(WORD_BITS);
   assign off_full    = MUL_W'(idx_ff) - word_scaled;

   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         op_ff  <= req_type;
         idx_ff <= bit_index;
      end
      prod_ff <= PROD_W'(idx_ff) * PROD_W'(RECIP);
      word_ff <= prod_ff[SH +: IDX_W];
      off_ff  <= off_full[OFF_W-1:0];
   end

   // Single bit operations
   logic [LEN_W-1:0]     idx_ext;
   logic                 in_range, grow_ok, bit_err, bit_wr;
   logic                 sel_bit;
   logic [WORD_BITS-1:0] bit_mask, bit_word;

   assign idx_ext  = LEN_W'(idx_ff);
   assign in_range = idx_ext < len_ff;
   assign grow_ok  = grow_ff && (idx_ext < LEN_W'(CAPACITY_BITS));
   assign sel_bit  = rd_data_ff[off_ff];
   assign bit_mask = WORD_BITS'(1) << off_ff;

   always_comb begin
      bit_err  = !in_range;
      bit_wr   = 1'b0;
      bit_word = rd_data_ff;
      len_in   = len_ff;
      unique case (op_ff)
         OP_SET: begin
            bit_err  = !in_range && !grow_ok;
            bit_wr   = in_range || grow_ok;
            bit_word = rd_data_ff | bit_mask;
            if (!in_range && grow_ok) begin
               len_in = idx_ext + LEN_W'(1);
            end
         end
         OP_CLEAR: begin
            bit_wr   = in_range;
            bit_word = rd_data_ff & ~bit_mask;
         end
         default: begin
         end
      endcase
   end

   // Search over the stored words
   logic                 want, last_mode, issue_more, hit;
   logic [BASE_W-1:0]    remain;
   logic [WORD_BITS-1:0] pattern;
   logic [OFF_W-1:0]     pos;
   logic [IDX_W-1:0]     cand;

   assign want       = (op_ff == OP_FIRST_SET) || (op_ff == OP_LAST_SET);
   assign last_mode  = (op_ff == OP_LAST_SET) || (op_ff == OP_LAST_CLEAR);
   assign issue_more = base_iss_ff < BASE_W'(len_ff);
   assign remain     = BASE_W'(len_ff) - ev_base_ff;
   assign hit        = ev_valid_ff && (pattern != '0);
   assign cand       = IDX_W'(ev_base_ff + BASE_W'(pos));

   always_comb begin
      for (int b = 0; b < WORD_BITS; b++) begin
         pattern[b] = (want ? rd_data_ff[b] : !rd_data_ff[b]) && (BASE_W'(b) < remain);
      end
      pos = '0;
      if (last_mode) begin
         for (int b = 0; b < WORD_BITS; b++) begin
            if (pattern[b]) begin
               pos = OFF_W'(b);
            end
         end
      end else begin
         for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (pattern[b]) begin
               pos = OFF_W'(b);
            end
         end
      end
   end

   // Memory port selection
   logic                 mem_we, mem_re, scan_issue;
   logic [AW-1:0]        mem_waddr, mem_raddr;
   logic [WORD_BITS-1:0] mem_wdata;

   assign scan_issue = cmd.scan_step && issue_more;
   assign mem_we     = cmd.clr_write || (cmd.commit && bit_wr);
   assign mem_waddr  = cmd.clr_write ? cnt_ff : word_ff[AW-1:0];
   assign mem_wdata  = cmd.clr_write ? '0 : bit_word;
   assign mem_re     = cmd.rd_bit || scan_issue;
   assign mem_raddr  = cmd.rd_bit ? word_ff[AW-1:0] : cnt_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         word_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= word_mem[mem_raddr];
      end
   end

   // Sweep and scan counters
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff      <= '0;
         ev_valid_ff <= 1'b0;
      end else if (cmd.clr_start || cmd.scan_start) begin
         cnt_ff      <= '0;
         ev_valid_ff <= 1'b0;
      end else begin
         if (cmd.clr_write || scan_issue) begin
            cnt_ff <= cnt_ff + AW'(1);
         end
         ev_valid_ff <= scan_issue;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_start) begin
         base_iss_ff <= '0;
         found_ff    <= 1'b0;
         fidx_ff     <= '0;
      end else begin
         if (scan_issue) begin
            base_iss_ff <= base_iss_ff + BASE_W'(WORD_BITS);
            ev_base_ff  <= base_iss_ff;
         end
         if (hit && (last_mode || !found_ff)) begin
            found_ff <= 1'b1;
            fidx_ff  <= cand;
         end
      end
   end

   // Length and grow enable
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff  <= LEN_W'(LEN_RST);
         grow_ff <= 1'b0;
      end else if (csr_we && (csr_index == CSR_START_LENGTH)) begin
         if (32'(csr_wdata) > CAPACITY_BITS) begin
            len_ff <= LEN_W'(CAPACITY_BITS);
         end else begin
            len_ff <= LEN_W'(csr_wdata);
         end
      end else if (csr_we && (csr_index == CSR_GROW_ENABLE)) begin
         grow_ff <= csr_wdata[0];
      end else if (cmd.commit) begin
         len_ff <= len_in;
      end
   end

   // Result register
   logic bit_op;
   assign bit_op = (op_ff == OP_GET) || (op_ff == OP_SET) || (op_ff == OP_CLEAR);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.res_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.res_load) begin
         rsp_bit_ff   <= (op_ff == OP_GET) && in_range && sel_bit;
         rsp_err_ff   <= bit_op && bit_err;
         rsp_len_ff   <= bit_op ? len_in : len_ff;
         rsp_found_ff <= !bit_op && (op_ff != OP_CLEAR_ALL) && found_ff;
         rsp_fidx_ff  <= (!bit_op && (op_ff != OP_CLEAR_ALL)) ? fidx_ff : '0;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_bit_value   = rsp_bit_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_found_index = rsp_fidx_ff;
   assign rsp_length_now  = rsp_len_ff;
   assign rsp_error_code  = rsp_err_ff;

   // Of the request, the controller looks only at the operation being offered.
   assign status.clr_last  = cnt_ff == AW'(WORD_COUNT - 1);
   assign status.scan_done = !issue_more && !ev_valid_ff;
   assign status.rsp_free  = !rsp_valid_ff || rsp_ready;
   assign status.op        = req_type;

endmodule
